// ===== src/fexp_pkg.sv =====
// ----------------------------------------------------------------------------
// fexp_pkg
// Shared types, single-precision constants and rounding helpers for the
// fast exponential pipeline.
// ----------------------------------------------------------------------------
package fexp_pkg;

  localparam logic [31:0] LN2_BITS     = 32'h3F317218;
  localparam logic [31:0] INV_LN2_BITS = 32'h3FB8AA3B;
  localparam logic [31:0] QNAN_BITS    = 32'h7FC00000;
  localparam logic [31:0] PINF_BITS    = 32'h7F800000;
  localparam logic [7:0]  EXP_BIAS     = 8'd127;

  // Horner coefficients, highest order first
  localparam logic [31:0] COEF [5] = '{
    32'h3D72AEBC, 32'h3E1EDEB6, 32'h3F00CA36, 32'h3F7FEBA5, 32'h3F80003D
  };

  // Sideband that travels with each beat
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  biased;
    logic        nan;
    logic        over;
    logic        under;
  } fexp_side_t;

  // Significand with hidden bit; subnormals get a zero hidden bit
  function automatic logic [23:0] fp_mant(input logic [31:0] f);
    fp_mant = {(f[30:23] != 8'd0), f[22:0]};
  endfunction

  // Biased exponent as used in arithmetic; subnormals sit at exponent 1
  function automatic logic signed [9:0] fp_exp(input logic [31:0] f);
    fp_exp = (f[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, f[30:23]});
  endfunction

  // Round to nearest even. sig[25] is the leading one, sig[24:2] the
  // fraction, sig[1] the guard bit and sig[0] the sticky bit.
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [9:0] e,
                                           input logic [25:0] sig, input logic zero);
    logic [9:0]  sh;
    logic [4:0]  shc;
    logic [51:0] wide;
    logic [25:0] s;
    logic [7:0]  ef;
    logic [30:0] pack;
    logic        inc;
    s  = sig;
    ef = e[7:0];
    sh = 10'd1 - e;
    if (e <= 10'sd0) begin
      shc  = (sh > 10'd26) ? 5'd26 : sh[4:0];
      wide = {sig, 26'd0} >> shc;
      s    = {wide[51:27], wide[26] | (|wide[25:0])};
      ef   = 8'd0;
    end
    pack = {ef, s[24:2]};
    inc  = s[1] & (s[0] | s[2]);
    if (zero) begin
      fp_round = {sign, 31'd0};
    end else if (e > 10'sd254) begin
      fp_round = {sign, PINF_BITS[30:0]};
    end else begin
      fp_round = {sign, pack + {30'd0, inc}};
    end
  endfunction

endpackage

// ===== src/fexp_fmul.sv =====
// ----------------------------------------------------------------------------
// fexp_fmul
// Three-stage single-precision multiplier: multiply, normalize, round.
// ----------------------------------------------------------------------------
module fexp_fmul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  input  fexp_pkg::fexp_side_t side_in,
  output logic                 v,
  output logic [31:0]          r,
  output fexp_pkg::fexp_side_t side_out
);
  import fexp_pkg::*;

  logic              v1, v2;
  logic              sign1, sign2;
  logic signed [9:0] es1, e2;
  logic [47:0]       prod1;
  logic [25:0]       sig2;
  logic              zero2;
  fexp_side_t        side1, side2;

  logic [5:0]  lz;
  logic [47:0] norm;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (prod1[i]) lz = 6'(47 - i);
    end
    norm = prod1 << lz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v  <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      v  <= v2;
    end
    if (en) begin
      // multiply
      sign1 <= a[31] ^ b[31];
      es1   <= fp_exp(a) + fp_exp(b) - 10'sd127;
      prod1 <= fp_mant(a) * fp_mant(b);
      side1 <= side_in;
      // normalize
      sign2 <= sign1;
      e2    <= es1 + 10'sd1 - $signed({4'd0, lz});
      sig2  <= {norm[47:23], |norm[22:0]};
      zero2 <= (prod1 == 48'd0);
      side2 <= side1;
      // round
      r        <= fp_round(sign2, e2, sig2, zero2);
      side_out <= side2;
    end
  end

endmodule

// ===== src/fexp_fadd.sv =====
// ----------------------------------------------------------------------------
// fexp_fadd
// Three-stage single-precision adder: align and add, normalize, round.
// ----------------------------------------------------------------------------
module fexp_fadd (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  input  fexp_pkg::fexp_side_t side_in,
  output logic                 v,
  output logic [31:0]          r,
  output fexp_pkg::fexp_side_t side_out
);
  import fexp_pkg::*;

  logic [31:0]       big, sml;
  logic signed [9:0] dexp;
  logic [4:0]        dclamp;
  logic [53:0]       alw;
  logic [26:0]       sml_al;
  logic [27:0]       sum;
  logic              sign_c;

  always_comb begin
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    dexp   = fp_exp(big) - fp_exp(sml);
    dclamp = (dexp > 10'sd27) ? 5'd27 : dexp[4:0];
    alw    = {fp_mant(sml), 3'd0, 27'd0} >> dclamp;
    sml_al = {alw[53:28], alw[27] | (|alw[26:0])};
    if (big[31] == sml[31]) sum = {1'b0, fp_mant(big), 3'd0} + {1'b0, sml_al};
    else                    sum = {1'b0, fp_mant(big), 3'd0} - {1'b0, sml_al};
    // exact zero: +0 unless both operands are negative
    sign_c = (sum == 28'd0) ? (a[31] & b[31]) : big[31];
  end

  logic              v1, v2;
  logic              sign1, sign2;
  logic signed [9:0] e1, e2;
  logic [27:0]       sum1;
  logic [25:0]       sig2;
  logic              zero2;
  fexp_side_t        side1, side2;
  logic [4:0]        lz;
  logic [27:0]       norm;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (sum1[i]) lz = 5'(27 - i);
    end
    norm = sum1 << lz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v  <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      v  <= v2;
    end
    if (en) begin
      sign1 <= sign_c;
      e1    <= fp_exp(big);
      sum1  <= sum;
      side1 <= side_in;
      sign2 <= sign1;
      e2    <= e1 + 10'sd1 - $signed({5'd0, lz});
      sig2  <= {norm[27:3], |norm[2:0]};
      zero2 <= (sum1 == 28'd0);
      side2 <= side1;
      r        <= fp_round(sign2, e2, sig2, zero2);
      side_out <= side2;
    end
  end

endmodule

// ===== src/fexp_reduce.sv =====
// ----------------------------------------------------------------------------
// fexp_reduce
// One stage: floor of x/ln2 as an integral float, the biased exponent of
// 2^k, and the out-of-range flags.
// ----------------------------------------------------------------------------
module fexp_reduce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [31:0]          t,
  input  fexp_pkg::fexp_side_t side_in,
  output logic                 v,
  output logic [31:0]          kf,
  output fexp_pkg::fexp_side_t side_out
);
  import fexp_pkg::*;

  logic              neg, tz, fnz;
  logic [7:0]        e;
  logic [4:0]        sh;
  logic [23:0]       mant, shifted;
  logic [7:0]        mag, nrm;
  logic [2:0]        lz;
  logic signed [8:0] kint;
  logic              over, under;
  logic [31:0]       kf_next;
  fexp_side_t        side_next;

  always_comb begin
    neg     = t[31];
    e       = t[30:23];
    tz      = (t[30:0] == 31'd0);
    mant    = {1'b1, t[22:0]};
    sh      = 5'(8'd150 - e);
    shifted = mant >> sh;
    fnz     = |(mant & ((24'd1 << sh) - 24'd1));
    if (e < EXP_BIAS) mag = {7'd0, neg & !tz};
    else              mag = shifted[7:0] + {7'd0, neg & fnz};
    kint  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    over  = !neg && (e >= 8'd134);
    under = neg && ((e >= 8'd134) || (kint <= -9'sd127));
    lz = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) lz = 3'(7 - i);
    end
    nrm = mag << lz;
    if (mag == 8'd0) kf_next = {neg, 31'd0};
    else             kf_next = {neg, 8'(8'd134 - {5'd0, lz}), nrm[6:0], 16'd0};
    side_next        = side_in;
    side_next.biased = 8'(kint + 9'sd127);
    side_next.over   = over;
    side_next.under  = under;
  end

  always_ff @(posedge clk) begin
    if (rst)     v <= 1'b0;
    else if (en) v <= in_v;
    if (en) begin
      kf       <= kf_next;
      side_out <= side_next;
    end
  end

endmodule

// ===== src/fast_exp_float32_core.sv =====
// ----------------------------------------------------------------------------
// fast_exp_float32_core
// Streaming single-precision exp(x): range reduction, degree-4 Horner
// polynomial and scaling by 2^k, each step a rounded float operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid / in_stall carries x_bits, one beat per value.
//   Output channel out_valid / out_stall carries result_bits with the
//   overflowed and underflowed flags, one beat per input beat, in order.
//   Throughput is one beat per cycle unless the receiver stalls: the
//   pipeline has seven three-stage multipliers, five three-stage adders,
//   one floor stage and an output register, each holding one beat.
//   When the receiver stalls with a beat waiting at the output, the whole
//   pipeline holds and in_stall rises in the same cycle; nothing is dropped
//   or repeated, and bubbles stay in place until the stall clears.
//   Reset clears every valid bit; no beat is lost or created afterwards.
//   A NaN input gives the quiet NaN with no flags. An exponent of 2^k past
//   the top of the range forces +infinity with overflowed set; one below
//   the bottom forces +0 with underflowed set.
// ----------------------------------------------------------------------------
module fast_exp_float32_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] x_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits,
  output logic        overflowed,
  output logic        underflowed
);
  import fexp_pkg::*;

  logic       en;
  fexp_side_t side0;

  // hold everything while the output beat waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    side0     = '0;
    side0.x   = x_bits;
    side0.nan = (x_bits[30:23] == 8'hFF) && (x_bits[22:0] != 23'd0);
  end

  // t = x / ln2
  logic       t_v;
  logic [31:0] t_r;
  fexp_side_t t_s;
  fexp_fmul u_mul_t (
    .clk(clk), .rst(rst), .en(en), .in_v(in_valid), .a(x_bits), .b(INV_LN2_BITS),
    .side_in(side0), .v(t_v), .r(t_r), .side_out(t_s)
  );

  // k = floor(t)
  logic        k_v;
  logic [31:0] k_f;
  fexp_side_t  k_s;
  fexp_reduce u_reduce (
    .clk(clk), .rst(rst), .en(en), .in_v(t_v), .t(t_r), .side_in(t_s),
    .v(k_v), .kf(k_f), .side_out(k_s)
  );

  // k * ln2
  logic        kl_v;
  logic [31:0] kl_r;
  fexp_side_t  kl_s;
  fexp_fmul u_mul_kl (
    .clk(clk), .rst(rst), .en(en), .in_v(k_v), .a(k_f), .b(LN2_BITS),
    .side_in(k_s), .v(kl_v), .r(kl_r), .side_out(kl_s)
  );

  // y = x - k * ln2
  logic        y_v;
  logic [31:0] y_r;
  fexp_side_t  y_s, y_side;
  fexp_fadd u_add_y (
    .clk(clk), .rst(rst), .en(en), .in_v(kl_v), .a(kl_s.x), .b({~kl_r[31], kl_r[30:0]}),
    .side_in(kl_s), .v(y_v), .r(y_r), .side_out(y_s)
  );

  always_comb begin
    y_side   = y_s;
    y_side.y = y_r;
  end

  // Horner: p = p * y + c, starting from c0 * y
  logic        hv  [5];
  logic [31:0] hp  [5];
  fexp_side_t  hs  [5];
  logic        mv  [4];
  logic [31:0] mp  [4];
  fexp_side_t  ms  [4];

  assign hv[0] = y_v;
  assign hp[0] = COEF[0];
  assign hs[0] = y_side;

  for (genvar i = 0; i < 4; i++) begin : g_horner
    fexp_fmul u_mul (
      .clk(clk), .rst(rst), .en(en), .in_v(hv[i]), .a(hp[i]), .b(hs[i].y),
      .side_in(hs[i]), .v(mv[i]), .r(mp[i]), .side_out(ms[i])
    );
    fexp_fadd u_add (
      .clk(clk), .rst(rst), .en(en), .in_v(mv[i]), .a(mp[i]), .b(COEF[i+1]),
      .side_in(ms[i]), .v(hv[i+1]), .r(hp[i+1]), .side_out(hs[i+1])
    );
  end

  // r = p * 2^k
  logic        r_v;
  logic [31:0] r_r;
  fexp_side_t  r_s;
  fexp_fmul u_mul_scale (
    .clk(clk), .rst(rst), .en(en), .in_v(hv[4]), .a(hp[4]),
    .b({1'b0, hs[4].biased, 23'd0}), .side_in(hs[4]), .v(r_v), .r(r_r), .side_out(r_s)
  );

  // output register: apply the special cases
  always_ff @(posedge clk) begin
    if (rst)     out_valid <= 1'b0;
    else if (en) out_valid <= r_v;
    if (en) begin
      overflowed  <= !r_s.nan && r_s.over;
      underflowed <= !r_s.nan && !r_s.over && r_s.under;
      if (r_s.nan)        result_bits <= QNAN_BITS;
      else if (r_s.over)  result_bits <= PINF_BITS;
      else if (r_s.under) result_bits <= 32'd0;
      else                result_bits <= r_r;
    end
  end

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(overflowed && underflowed))
    else $error("both range flags set");

  a_over_inf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |-> (result_bits == PINF_BITS))
    else $error("overflow without +inf");

  a_under_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && underflowed) |-> (result_bits == 32'd0))
    else $error("underflow without +0");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_bits)))
    else $error("output beat lost while stalled");

endmodule

// ===== test/fast_exp_float32_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_exp_float32_core_test
// Streams single-precision values through the exp pipeline and checks every
// output beat against a bit-exact software model of the range reduction,
// the Horner polynomial and the 2^k scaling, under random idling on both
// channels, one long output stall episode and one drain pause.
// ----------------------------------------------------------------------------
module fast_exp_float32_core_test;
  import fexp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    logic [31:0] result;
    logic        over;
    logic        under;
  } exp_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] x_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_bits;
  logic        overflowed;
  logic        underflowed;

  exp_beat_t pending_exp[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        no_idle = 1'b0;
  bit        hold_req = 1'b0;

  fast_exp_float32_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_bits     (x_bits),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_bits(result_bits),
    .overflowed (overflowed),
    .underflowed(underflowed)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Float arithmetic model: exact integer math, then one RNE rounding step.
  // --------------------------------------------------------------------------

  // Round m * 2^e to single precision, nearest even, with subnormals.
  function automatic logic [31:0] round_single(input logic sgn, input int e,
                                               input logic [65:0] m);
    int         msb;
    int         u;
    int         sh;
    logic [65:0] q;
    logic        g;
    logic        st;
    if (m == '0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 66; i++) if (m[i]) msb = i;
    // unit of the last kept bit, never below the subnormal step
    u = msb + e - 23;
    if (u < -149) u = -149;
    sh = u - e;
    if (sh <= 0) begin
      q = m << (-sh);
      g = 1'b0;
      st = 1'b0;
    end else if (sh > 66) begin
      q = '0;
      g = 1'b0;
      st = 1'b1;
    end else begin
      q = m >> sh;
      g = m[sh-1];
      st = (m & ((66'd1 << (sh - 1)) - 66'd1)) != '0;
    end
    if (g && (st || q[0])) q = q + 66'd1;
    if (q[24]) begin
      q = q >> 1;
      u++;
    end
    if (!q[23]) return {sgn, 8'd0, q[22:0]};
    if (u + 150 >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(u + 150), q[22:0]};
  endfunction

  function automatic logic [65:0] sig_of(input logic [31:0] f);
    return {42'd0, (f[30:23] != 8'd0), f[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? 1 : int'(f[30:23]);
  endfunction

  function automatic logic [31:0] mul_single(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {sgn, PINF_BITS[30:0]};
    return round_single(sgn, exp_of(a) + exp_of(b) - 300, sig_of(a) * sig_of(b));
  endfunction

  // Finite operands only; far-away addends fold into a sticky bit
  function automatic logic [31:0] add_single(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [65:0] ma;
    logic [65:0] mb;
    int          d;
    if (exp_of(a) >= exp_of(b)) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    d  = exp_of(big) - exp_of(sml);
    ma = sig_of(big) << 40;
    mb = sig_of(sml);
    if (d <= 40) mb = mb << (40 - d);
    else if (d - 40 >= 24) mb = {65'd0, mb != '0};
    else mb = (mb >> (d - 40)) | {65'd0, (mb & ((66'd1 << (d - 40)) - 66'd1)) != '0};
    if (big[31] == sml[31]) return round_single(big[31], exp_of(big) - 190, ma + mb);
    if (ma == mb) return 32'd0;
    if (ma > mb) return round_single(big[31], exp_of(big) - 190, ma - mb);
    return round_single(sml[31], exp_of(big) - 190, mb - ma);
  endfunction

  // floor of a float as an integer, clamped far outside the usable range
  function automatic int floor_to_int(input logic [31:0] t);
    int          ex;
    logic [23:0] s;
    int          mag;
    bit          lost;
    ex = int'(t[30:23]);
    if (ex < 127) return (t[30:0] == '0 || !t[31]) ? 0 : -1;
    if (ex >= 135) return t[31] ? -1000 : 1000;
    s    = {1'b1, t[22:0]};
    mag  = int'(s >> (150 - ex));
    lost = (s & ((24'd1 << (150 - ex)) - 24'd1)) != '0;
    return t[31] ? -(mag + int'(lost)) : mag;
  endfunction

  function automatic exp_beat_t predict_exp(input logic [31:0] x);
    exp_beat_t   b;
    logic [31:0] t;
    logic [31:0] kf;
    logic [31:0] y;
    logic [31:0] p;
    int          k;
    b = '{result: 32'd0, over: 1'b0, under: 1'b0};
    if (x[30:23] == 8'hFF && x[22:0] != '0) begin
      b.result = QNAN_BITS;
      return b;
    end
    t = mul_single(x, INV_LN2_BITS);
    k = floor_to_int(t);
    if (k >= 128) begin
      b.result = PINF_BITS;
      b.over   = 1'b1;
      return b;
    end
    if (k <= -127) begin
      b.under = 1'b1;
      return b;
    end
    kf = round_single(k < 0, 0, 66'(k < 0 ? -k : k));
    y  = add_single(x, mul_single(kf, LN2_BITS) ^ 32'h80000000);
    p  = COEF[0];
    for (int i = 1; i < 5; i++) p = add_single(mul_single(p, y), COEF[i]);
    b.result = mul_single(p, {1'b0, 8'(k + 127), 23'd0});
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Channels
  // --------------------------------------------------------------------------

  // Offer one value, optionally after an idle cycle, and hold until taken.
  task automatic send_x(input logic [31:0] v);
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      x_bits   <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_bits   <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_exp.push_back(predict_exp(v));
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 13);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Compare each output beat with the oldest expected one
  always @(posedge clk) begin
    exp_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_exp.size() == 0) begin
        report_mismatch("unexpected beat", result_bits, 32'd0);
      end else begin
        want = pending_exp.pop_front();
        if (result_bits !== want.result) report_mismatch("result", result_bits, want.result);
        if (overflowed !== want.over)
          report_mismatch("overflowed", {31'd0, overflowed}, {31'd0, want.over});
        if (underflowed !== want.under)
          report_mismatch("underflowed", {31'd0, underflowed}, {31'd0, want.under});
      end
    end
  end

  // Watchdog: abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Value in roughly (-128, 128), which covers the range where the polynomial path runs
  function automatic logic [31:0] usable_x();
    return {1'($urandom), 8'($urandom_range(133, 90)), 23'($urandom)};
  endfunction

  task automatic wait_drained;
    while (pending_exp.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_values;
    logic [31:0] vals[$] = '{
      32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h7F800000,
      32'hFF800000, 32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h7F7FFFFF,
      32'hFF7FFFFF, 32'h00000001, 32'h80000001, 32'h42B17218, 32'h42B20000,
      32'hC2AE0000, 32'hC2CE0000, 32'hC2D00000, 32'h322BCC77, 32'h3F317218,
      32'hBF317218, 32'h42FE0000, 32'hC2FC0000, 32'h007FFFFF};
    foreach (vals[i]) send_x(vals[i]);
    end_burst();
  endtask

  task automatic test_random_values(input int n);
    repeat (n) send_x(($urandom_range(99) < 25) ? $urandom : usable_x());
    end_burst();
  endtask

  // Stall the output long enough for the pipeline to back up into the input
  task automatic test_backpressure;
    fork
      begin
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      test_random_values(120);
    join
  endtask

  // Stop sending until every result is back, then resume
  task automatic test_drain_pause;
    test_random_values(80);
    wait_drained();
    test_random_values(80);
  endtask

  task automatic test_no_idle;
    no_idle = 1'b1;
    test_random_values(300);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_values();
    test_random_values(600);
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    test_random_values(500);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fexp_pkg.sv
src/fexp_fmul.sv
src/fexp_fadd.sv
src/fexp_reduce.sv
src/fast_exp_float32_core.sv
test/fast_exp_float32_core_test.sv
